// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL scoreboard core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks expr at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Checks that cons holds in the same cycle as ante.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/vois_pkg.sv =====
// Package with the operation codes and register tables of the vector scoreboard.
package vois_pkg;

  localparam int REG_IDX_W  = 4;
  localparam int VEC_OUT_W  = 11;
  localparam int KIND_COUNT = 9;

  localparam logic [REG_IDX_W-1:0] REG_OUT = 4'd8;
  localparam logic [REG_IDX_W-1:0] REG_TA  = 4'd9;
  localparam logic [REG_IDX_W-1:0] REG_TB  = 4'd10;

  typedef enum logic [1:0] {
    MODE_ISSUE    = 2'd0,
    MODE_COMPLETE = 2'd1,
    MODE_WRITE    = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    KIND_VLOAD     = 4'd0,
    KIND_AAMUL02   = 4'd1,
    KIND_AAMUL12   = 4'd2,
    KIND_AAMUL21   = 4'd3,
    KIND_AAMUL31   = 4'd4,
    KIND_TRIADD012 = 4'd5,
    KIND_TRIADD321 = 4'd6,
    KIND_OACC      = 4'd7,
    KIND_VSTORE    = 4'd8
  } kind_t;

  typedef logic [VEC_OUT_W-1:0] vec_mask_t;

  function automatic vec_mask_t bit_of(logic [REG_IDX_W-1:0] idx);
    return vec_mask_t'(1) << idx;
  endfunction

  // Registers that must all be ready before a kind may issue.
  function automatic vec_mask_t need_mask(logic [3:0] kind);
    vec_mask_t m;
    m = '0;
    unique case (kind)
      KIND_VLOAD:     m = '0;
      KIND_AAMUL02:   m = bit_of(4'd0) | bit_of(4'd2);
      KIND_AAMUL12:   m = bit_of(4'd1) | bit_of(4'd2);
      KIND_AAMUL21:   m = bit_of(4'd2) | bit_of(4'd1);
      KIND_AAMUL31:   m = bit_of(4'd3) | bit_of(4'd1);
      KIND_TRIADD012: m = bit_of(4'd0) | bit_of(REG_TA) | bit_of(REG_TB);
      KIND_TRIADD321: m = bit_of(4'd3) | bit_of(REG_TB) | bit_of(REG_TA);
      KIND_OACC:      m = bit_of(REG_OUT) | bit_of(4'd0) | bit_of(4'd3);
      KIND_VSTORE:    m = bit_of(REG_OUT);
      default:        m = '0;
    endcase
    return m;
  endfunction

  // Register whose ready bit an issue clears and a completion sets.
  function automatic logic [REG_IDX_W-1:0] target_reg(logic [3:0] kind,
                                                      logic [REG_IDX_W-1:0] dest);
    logic [REG_IDX_W-1:0] t;
    t = '0;
    unique case (kind)
      KIND_VLOAD:     t = dest;
      KIND_AAMUL02:   t = 4'd0;
      KIND_AAMUL12:   t = REG_TA;
      KIND_AAMUL21:   t = REG_TB;
      KIND_AAMUL31:   t = 4'd3;
      KIND_TRIADD012: t = 4'd0;
      KIND_TRIADD321: t = 4'd3;
      KIND_OACC:      t = REG_OUT;
      KIND_VSTORE:    t = REG_OUT;
      default:        t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/vector_op_issue_scoreboard_core.sv =====
// Ready-bit scoreboard for the vector registers of the accelerator.
//
// Usage: raise start for one cycle with mode, op_kind, load_dest, entry_index
// and entry_value. Mode 0 checks whether the operation may issue and, if so,
// marks its target busy; mode 1 marks the target ready again on completion;
// mode 2 writes one ready bit directly.
// The transaction is taken at the edge where start is high and busy is low.
// busy stays low, so a new transaction may be taken in every cycle.
// An accepted transaction passes the input register, then the result
// register; done is then high for exactly one cycle with can_issue and
// ready_vector, the ready bits as they stand after the step. The input
// register feeds one level of decode and mask logic that updates the ready
// bits and the result register at the same edge, so the next transaction
// always sees the state left by the one before it: 1 transaction per cycle.
// The receiver cannot stall; each result is shown once and then replaced.
// Reset marks every register busy (ready bits 0) and drops any pending
// transaction; no result appears for it.
`include "assert_macros.svh"

module vector_op_issue_scoreboard_core
  import vois_pkg::*;
#(
  parameter int NUM_VECS = 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode,
  input  logic [3:0]           op_kind,
  input  logic [3:0]           load_dest,
  input  logic [3:0]           entry_index,
  input  logic                 entry_value,
  output logic                 done,
  output logic                 can_issue,
  output logic [VEC_OUT_W-1:0] ready_vector
);

  typedef logic [NUM_VECS-1:0] ready_t;

  // Input register.
  logic                 in_valid;
  logic [1:0]           in_mode;
  logic [3:0]           in_kind;
  logic [3:0]           in_dest;
  logic [3:0]           in_index;
  logic                 in_value;

  ready_t               ready_bits;
  ready_t               ready_bits_next;
  logic                 ok_next;

  ready_t               need;
  ready_t               tgt_bit;
  ready_t               wr_bit;
  logic                 kind_ok;
  logic                 tgt_ok;
  logic                 wr_ok;
  logic [3:0]           tgt_idx;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_mode  <= mode;
      in_kind  <= op_kind;
      in_dest  <= load_dest;
      in_index <= entry_index;
      in_value <= entry_value;
    end
  end

  always_comb begin
    kind_ok = int'(in_kind) < KIND_COUNT;
    need    = NUM_VECS'(need_mask(in_kind));
    tgt_idx = target_reg(in_kind, in_dest);
    tgt_ok  = kind_ok && (int'(tgt_idx) < NUM_VECS);
    tgt_bit = tgt_ok ? (NUM_VECS'(1) << tgt_idx) : '0;
    wr_ok   = int'(in_index) < NUM_VECS;
    wr_bit  = wr_ok ? (NUM_VECS'(1) << in_index) : '0;

    ready_bits_next = ready_bits;
    ok_next         = 1'b0;
    if (in_valid) begin
      unique case (in_mode)
        MODE_ISSUE: begin
          if (kind_ok && ((ready_bits & need) == need)) begin
            ok_next         = 1'b1;
            ready_bits_next = ready_bits & ~tgt_bit;
          end
        end
        MODE_COMPLETE: ready_bits_next = ready_bits | tgt_bit;
        MODE_WRITE: begin
          if (in_value) begin
            ready_bits_next = ready_bits | wr_bit;
          end else begin
            ready_bits_next = ready_bits & ~wr_bit;
          end
        end
        default: ready_bits_next = ready_bits;
      endcase
    end
  end

  // Result register and scoreboard state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ready_bits <= '0;
      done       <= 1'b0;
    end else begin
      ready_bits <= ready_bits_next;
      done       <= in_valid;
    end
    can_issue    <= ok_next;
    ready_vector <= ready_bits_next[VEC_OUT_W-1:0];
  end

  `ASSERT_SAME(a_issue_has_done, clk, rst, can_issue, done, "can_issue without done")
  `ASSERT_NEXT(a_non_issue_fails, clk, rst, in_valid && (in_mode != MODE_ISSUE), !can_issue, "can_issue outside an issue check")
  `ASSERT_NEXT(a_idle_holds_state, clk, rst, !in_valid, $stable(ready_bits), "ready bits changed without a transaction")
  `ASSERT_NEXT(a_vload_issues, clk, rst, in_valid && (in_mode == MODE_ISSUE) && (in_kind == KIND_VLOAD), can_issue, "vload did not issue")

endmodule
